// ===== rtl/core/chpwm_pkg.sv =====
// Package for the charlieplexed LED PWM driver.
// Holds widths, reset levels, the LED order table and the item, state and result types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package chpwm_pkg;

  localparam int unsigned LedCount = 6;
  localparam int unsigned PwmBits  = 6;
  localparam int unsigned LevelW   = 6;
  localparam int unsigned IdxW     = 3;
  localparam int unsigned ColW     = 2;
  localparam int unsigned PinCount = 3;
  localparam int unsigned LitW     = 2;
  localparam int unsigned CmpW     = (PwmBits > LevelW) ? PwmBits : LevelW;

  localparam int unsigned SDataW = ((IdxW + LevelW + 7) / 8) * 8;
  localparam int unsigned MDataW = ((2 * PinCount + 7) / 8) * 8;

  typedef logic [LevelW-1:0]  level_t;
  typedef logic [IdxW-1:0]    idx_t;
  typedef logic [PwmBits-1:0] ramp_t;
  typedef logic [ColW-1:0]    col_t;
  typedef logic [PinCount-1:0] pins_t;
  typedef logic [LitW-1:0]    lit_t;

  typedef level_t [LedCount-1:0] level_arr_t;
  typedef idx_t   [LedCount-1:0] order_arr_t;

  typedef enum logic {
    KindTick  = 1'b0,
    KindWrite = 1'b1
  } kind_e;

  localparam level_arr_t LevelInit = '{6'd10, 6'd0, 6'd0, 6'd0, 6'd10, 6'd63};
  localparam order_arr_t LedOrder  = '{3'd4, 3'd3, 3'd1, 3'd5, 3'd2, 3'd0};

  localparam col_t  LastCol    = col_t'(2);
  localparam col_t  ClampCol   = col_t'(3);
  localparam idx_t  ClampFirst = idx_t'(4);
  localparam lit_t  LitBoth    = 2'b11;
  localparam pins_t ColFirst   = pins_t'(1);

  typedef struct packed {
    kind_e  kind;
    idx_t   led_index;
    level_t level_value;
  } item_t;

  typedef struct packed {
    ramp_t ramp;
    col_t  col_idx;
    pins_t col_oh;
    lit_t  lit;
  } state_t;

  typedef struct packed {
    pins_t pin_drive;
    pins_t pin_high;
    logic  frame_start;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/chpwm_step.sv =====
// Next-state and result logic for one item of the charlieplexed LED PWM driver.
// Depends on chpwm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module chpwm_step import chpwm_pkg::*; (
  input  item_t      item_i,
  input  state_t     state_i,
  input  level_arr_t levels_i,
  output state_t     state_o,
  output level_arr_t levels_o,
  output result_t    result_o
);

  ramp_t  ramp_n;
  logic   wrapped;
  col_t   col_n;
  pins_t  oh_n;
  lit_t   lit_w;
  lit_t   lit_n;
  idx_t   sel0;
  idx_t   sel1;
  level_t lvl0;
  level_t lvl1;
  logic   eq0;
  logic   eq1;
  pins_t  mask;
  pins_t  lit_ext;
  pins_t  spread;

  always_comb begin
    ramp_n  = ramp_t'(state_i.ramp + 1'b1);
    wrapped = (ramp_n == '0);
    if (wrapped) begin
      col_n = (state_i.col_idx >= LastCol) ? '0 : col_t'(state_i.col_idx + 1'b1);
      oh_n  = pins_t'(ColFirst << col_n);
      lit_w = LitBoth;
    end else begin
      col_n = state_i.col_idx;
      oh_n  = state_i.col_oh;
      lit_w = state_i.lit;
    end

    sel0 = (col_n == ClampCol) ? ClampFirst : idx_t'({col_n, 1'b0});
    sel1 = idx_t'(sel0 + 1'b1);
    lvl0 = levels_i[LedOrder[sel0]];
    lvl1 = levels_i[LedOrder[sel1]];
    eq0  = (CmpW'(lvl0) == CmpW'(ramp_n));
    eq1  = (CmpW'(lvl1) == CmpW'(ramp_n));
    lit_n = lit_w & ~{eq1, eq0};

    mask    = pins_t'(oh_n - 1'b1);
    lit_ext = pins_t'(lit_n);
    spread  = (lit_ext & mask) | pins_t'((lit_ext & ~mask) << 1);
  end

  always_comb begin
    state_o  = state_i;
    levels_o = levels_i;
    if (item_i.kind == KindWrite) begin
      if (item_i.led_index < idx_t'(LedCount)) begin
        levels_o[item_i.led_index] = item_i.level_value;
      end
    end else begin
      state_o.ramp    = ramp_n;
      state_o.col_idx = col_n;
      state_o.col_oh  = oh_n;
      state_o.lit     = lit_n;
    end
  end

  assign result_o.pin_drive   = spread | oh_n;
  assign result_o.pin_high    = spread;
  assign result_o.frame_start = wrapped;

endmodule

`default_nettype wire

// ===== rtl/core/charlieplex_pwm_led_driver_unit.sv =====
// Top level of the charlieplexed LED PWM driver: input register, state, result register.
// Depends on chpwm_pkg and chpwm_step.
//
//   channel  | dir | tdata                             | tuser
//   s_axis   | in  | [2:0] led_index, [8:3] level_value | [0] kind (0 tick, 1 write)
//   m_axis   | out | [2:0] pin_drive, [5:3] pin_high   | [0] frame_start
//
// Each word is registered in the input register and a tick's result in the result register,
// so a new word is taken every cycle at full rate unless a tick waits on a stalled result.
// A write word with an LED index in range updates the level table; no write gives a result.
// Reset clears the ramp, column and LED bits and loads the default levels.
// A stalled result holds back only a tick in the input register; a write there still advances.
`timescale 1ns / 1ps
`default_nettype none

module charlieplex_pwm_led_driver_unit import chpwm_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [SDataW-1:0] s_axis_tdata,  // led_index, level_value
  input  wire logic              s_axis_tuser,  // kind
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [MDataW-1:0] m_axis_tdata,  // pin_drive, pin_high
  output logic                   m_axis_tuser   // frame_start
);

  logic       in_valid_q;
  item_t      in_item_q;
  item_t      in_item_d;
  logic       out_valid_q;
  result_t    out_q;
  state_t     state_q;
  state_t     state_d;
  level_arr_t levels_q;
  level_arr_t levels_d;
  result_t    result;
  logic       advance;
  logic       is_tick;

  assign in_item_d.kind        = kind_e'(s_axis_tuser);
  assign in_item_d.led_index   = s_axis_tdata[IdxW-1:0];
  assign in_item_d.level_value = s_axis_tdata[IdxW+LevelW-1:IdxW];

  assign is_tick       = (in_item_q.kind == KindTick);
  assign advance       = in_valid_q && (!is_tick || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  chpwm_step u_step (
    .item_i   (in_item_q),
    .state_i  (state_q),
    .levels_i (levels_q),
    .state_o  (state_d),
    .levels_o (levels_d),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= in_item_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= '0;
      levels_q <= LevelInit;
    end else if (advance) begin
      state_q  <= state_d;
      levels_q <= levels_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && is_tick) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && is_tick) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = MDataW'({out_q.pin_high, out_q.pin_drive});
  assign m_axis_tuser  = out_q.frame_start;

endmodule

`default_nettype wire

// ===== rtl/core/chpwm_checker.sv =====
// Port-level checks for the charlieplexed LED PWM driver, bound to the top level.
// Depends on chpwm_pkg and charlieplex_pwm_led_driver_unit.
`timescale 1ns / 1ps
`default_nettype none

module chpwm_checker import chpwm_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [MDataW-1:0] m_axis_tdata,
  input wire logic              m_axis_tuser
);

  pins_t drive;
  pins_t high;

  assign drive = m_axis_tdata[PinCount-1:0];
  assign high  = m_axis_tdata[2*PinCount-1:PinCount];

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((high & ~drive) == '0))
    else $error("A high pin is not driven.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (drive != '0)) |-> ($countones(drive) == $countones(high) + 1))
    else $error("Exactly one column pin must be driven low.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> (drive != '0))
    else $error("A frame start must select a column.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("A stalled result word changed.");

endmodule

bind charlieplex_pwm_led_driver_unit chpwm_checker u_chpwm_checker (.*);

`default_nettype wire

// ===== verif/tb_charlieplex_pwm_led_driver_unit.sv =====
// Testbench for the charlieplexed LED PWM driver: directed level writes and ticks, then random
// traffic in three idling phases, every result checked against an in-bench prediction.
// Depends on chpwm_pkg and charlieplex_pwm_led_driver_unit.
`timescale 1ns / 1ps

module tb_charlieplex_pwm_led_driver_unit;
  import chpwm_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int PhaseWords = 440;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [SDataW-1:0] s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [MDataW-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  charlieplex_pwm_led_driver_unit DUT (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  item_t   word_q[$];
  result_t pin_expect_q[$];
  item_t   cur_word;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      errors = 0;
  int      n_ticks = 0;
  int      n_writes = 0;
  int      n_checked = 0;
  int      n_frames = 0;
  int      cycles = 0;

  // Predicted driver state.
  ramp_t  ramp_q = '0;
  col_t   col_q = '0;
  pins_t  col_oh_q = '0;
  lit_t   lit_q = '0;
  level_t levels_q[LedCount] = '{6'd63, 6'd10, 6'd0, 6'd0, 6'd0, 6'd10};
  idx_t   order_tbl[LedCount] = '{3'd0, 3'd2, 3'd5, 3'd1, 3'd3, 3'd4};

  function automatic bit advance_pwm(input item_t it, output result_t res);
    logic  wrapped;
    int    first;
    pins_t mask;
    pins_t lit3;
    pins_t spread;
    res = '0;
    if (it.kind == KindWrite) begin
      if (it.led_index < LedCount) levels_q[it.led_index] = it.level_value;
      return 1'b0;
    end
    ramp_q = ramp_q + 1'b1;
    wrapped = (ramp_q == '0);
    if (wrapped) begin
      lit_q = 2'b11;
      col_q = (col_q >= 2'd2) ? 2'd0 : col_q + 2'd1;
      col_oh_q = pins_t'(1) << col_q;
    end
    first = (col_q * 2 > 4) ? 4 : col_q * 2;
    if (levels_q[order_tbl[first]] == ramp_q) lit_q = lit_q & 2'b10;
    if (levels_q[order_tbl[first + 1]] == ramp_q) lit_q = lit_q & 2'b01;
    mask = col_oh_q - 3'd1;
    lit3 = {1'b0, lit_q};
    spread = (lit3 & mask) | ((lit3 & ~mask) << 1);
    res.pin_drive = spread | col_oh_q;
    res.pin_high = spread;
    res.frame_start = wrapped;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (errors < 20) $display("MISMATCH %s: got %0d, expected %0d", what, got, want);
    errors++;
  endtask

  task automatic push_word(input kind_e k, input int idx, input int lvl);
    item_t it;
    it.kind = k;
    it.led_index = idx_t'(idx);
    it.level_value = level_t'(lvl);
    word_q.push_back(it);
  endtask

  task automatic drain_all();
    @(posedge clk_i);
    @(negedge clk_i);
    while (word_q.size() != 0 || s_axis_tvalid || pin_expect_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    logic    accepted;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
      s_axis_tuser <= 1'b0;
    end else begin
      accepted = s_axis_tvalid && s_axis_tready;
      if (accepted) begin
        if (cur_word.kind == KindWrite) n_writes++;
        else n_ticks++;
        if (advance_pwm(cur_word, res)) pin_expect_q.push_back(res);
      end
      if (!s_axis_tvalid || accepted) begin
        if (word_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_word = word_q.pop_front();
          s_axis_tdata <= SDataW'({cur_word.level_value, cur_word.led_index});
          s_axis_tuser <= cur_word.kind;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pin_expect_q.size() == 0) begin
          report_mismatch("unexpected word, pin_drive", m_axis_tdata[2:0], 0);
        end else begin
          want = pin_expect_q.pop_front();
          n_checked++;
          if (m_axis_tuser) n_frames++;
          if (m_axis_tdata[2:0] != want.pin_drive)
            report_mismatch("pin_drive", m_axis_tdata[2:0], want.pin_drive);
          if (m_axis_tdata[5:3] != want.pin_high)
            report_mismatch("pin_high", m_axis_tdata[5:3], want.pin_high);
          if (m_axis_tuser != want.frame_start)
            report_mismatch("frame_start", m_axis_tuser, want.frame_start);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pin_expect_q.size());
      $display("tb_charlieplex_pwm_led_driver_unit failed");
      $finish;
    end
  end

  task automatic random_phase(input int s_pct, input int r_pct);
    int n;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (n = 0; n < PhaseWords; n++) begin
      if ($urandom_range(99) < 18) begin
        if ($urandom_range(7) == 0) push_word(KindWrite, $urandom_range(7),
                                              $urandom_range(1) ? 63 : 0);
        else push_word(KindWrite, $urandom_range(7), $urandom_range(63));
      end else begin
        push_word(KindTick, $urandom_range(7), $urandom_range(63));
      end
    end
    drain_all();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Ticks before the first wrap must leave every pin undriven.
    push_word(KindTick, 7, 63);
    push_word(KindTick, 0, 0);
    push_word(KindWrite, 0, 63);
    push_word(KindWrite, 1, 0);
    push_word(KindWrite, 2, 2);
    push_word(KindWrite, 3, 1);
    push_word(KindWrite, 4, 63);
    push_word(KindWrite, 5, 0);
    // Out-of-range LED indexes are ignored.
    push_word(KindWrite, 6, 63);
    push_word(KindWrite, 7, 0);
    push_word(KindWrite, 6, 21);
    push_word(KindWrite, 7, 42);
    repeat (8) push_word(KindTick, $urandom_range(7), $urandom_range(63));
    push_word(KindWrite, 2, 5);
    push_word(KindTick, 5, 42);
    drain_all();

    random_phase(34, 52);
    random_phase(52, 34);
    random_phase(0, 0);

    repeat (10) @(posedge clk_i);
    $display("covered %0d ticks and %0d level writes, %0d words checked over %0d frames",
             n_ticks, n_writes, n_checked, n_frames);
    $display("idling phases: sender 34/receiver 52, sender 52/receiver 34, none; %0d errors",
             errors);
    if (errors == 0 && pin_expect_q.size() == 0) begin
      $display("tb_charlieplex_pwm_led_driver_unit passed");
    end else begin
      $display("tb_charlieplex_pwm_led_driver_unit failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/chpwm_pkg.sv
rtl/core/chpwm_step.sv
rtl/core/charlieplex_pwm_led_driver_unit.sv
rtl/core/chpwm_checker.sv
verif/tb_charlieplex_pwm_led_driver_unit.sv
